/* hdl/pfsp_pkg.sv */
package pfsp_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 32;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
    localparam int SUM_BYTES   = FRAME_BYTES - 2;

    // payload widths
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int SKIP_W    = 6;
    localparam int NUM_WORDS = 7;
    localparam int STATUS_W  = 2;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h42;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_COLLECT = 2'd0,
        ST_GOOD    = 2'd1,
        ST_RESYNC  = 2'd2
    } status_t;

    typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] frame_t;

    // one result item, words in frame order starting at byte 2
    typedef struct packed {
        status_t                           status;
        logic [SKIP_W-1:0]                 resync_skip;
        logic [NUM_WORDS-1:0][WORD_W-1:0]  words;
    } result_t;

endpackage

/* hdl/pfsp_in_if.sv */
interface pfsp_in_if
    import pfsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hdl/pfsp_out_if.sv */
interface pfsp_out_if
    import pfsp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SKIP_W-1:0]   resync_skip;
    logic [WORD_W-1:0]   frame_length;
    logic [WORD_W-1:0]   pm1_standard;
    logic [WORD_W-1:0]   pm2p5_standard;
    logic [WORD_W-1:0]   pm10p0_standard;
    logic [WORD_W-1:0]   pm1_env;
    logic [WORD_W-1:0]   pm2p5_env;
    logic [WORD_W-1:0]   pm10p0_env;

    modport source (
        output valid, output status, output resync_skip, output frame_length,
        output pm1_standard, output pm2p5_standard, output pm10p0_standard,
        output pm1_env, output pm2p5_env, output pm10p0_env,
        input ready
    );
    modport sink (
        input valid, input status, input resync_skip, input frame_length,
        input pm1_standard, input pm2p5_standard, input pm10p0_standard,
        input pm1_env, input pm2p5_env, input pm10p0_env,
        output ready
    );
endinterface

/* hdl/pfsp_frame_eval.sv */
module pfsp_frame_eval
    import pfsp_pkg::*;
(
    input  frame_t              store,
    input  logic [FILL_W-1:0]   fill,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic [BYTE_W-1:0]   header_byte,
    output frame_t              store_next,
    output logic [FILL_W-1:0]   fill_next,
    output result_t             result
);

    logic                kept;
    logic                complete;
    logic                good;
    frame_t              frame_full;
    frame_t              shifted;
    logic [WORD_W-1:0]   sum;
    logic [WORD_W-1:0]   check;
    logic [FILL_W-1:0]   start;

    // byte at a fixed position, zero past the frame end
    function automatic logic [BYTE_W-1:0] byte_at(frame_t f, int pos);
        logic [BYTE_W-1:0] v;
        v = '0;
        if (pos < FRAME_BYTES)
            v = f[IDX_W'(pos)];
        return v;
    endfunction

    // slot 0 takes only the header byte
    assign kept     = (fill != '0) || (rx_byte == header_byte);
    assign complete = kept && (fill == FILL_W'(FRAME_BYTES - 1));

    // frame as it stands once this item lands in the last slot
    always_comb
    begin
        frame_full = store;
        frame_full[FRAME_BYTES-1] = rx_byte;
    end

    // parallel checksum over the first SUM_BYTES frame bytes, all but the two checksum bytes
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < SUM_BYTES; i++)
            sum = sum + WORD_W'(store[i]);
    end

    assign check = {store[FRAME_BYTES-2], rx_byte};
    assign good  = complete && (sum == check);

    // first header byte after slot 0, frame length if none
    always_comb
    begin
        start = FILL_W'(FRAME_BYTES);
        for (int i = FRAME_BYTES - 1; i >= 1; i--)
        begin
            if (frame_full[i] == header_byte)
                start = FILL_W'(i);
        end
    end

    // move the frame down so the found header sits in slot 0
    always_comb
    begin
        logic [FILL_W:0] src;
        shifted = frame_full;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            src = (FILL_W + 1)'(i) + {1'b0, start};
            if (src < (FILL_W + 1)'(FRAME_BYTES))
                shifted[i] = frame_full[src[IDX_W-1:0]];
        end
    end

    // next state and result item
    always_comb
    begin
        store_next         = store;
        fill_next          = fill;
        result.status      = ST_COLLECT;
        result.resync_skip = '0;
        result.words       = '0;
        if (kept)
        begin
            store_next[fill[IDX_W-1:0]] = rx_byte;
            fill_next = fill + FILL_W'(1);
        end
        if (complete)
        begin
            if (good)
            begin
                fill_next     = '0;
                result.status = ST_GOOD;
                for (int j = 0; j < NUM_WORDS; j++)
                    result.words[j] = {byte_at(frame_full, 2 + 2 * j),
                                       byte_at(frame_full, 3 + 2 * j)};
            end
            else
            begin
                store_next         = shifted;
                fill_next          = FILL_W'(FRAME_BYTES) - start;
                result.status      = ST_RESYNC;
                result.resync_skip = SKIP_W'(start);
            end
        end
    end

endmodule

/* hdl/particle_frame_sync_parser.sv */
// an accepted item is held in the input register, then its result item is loaded into the
//   result register, from which it can be taken
// throughput: one byte per cycle while the result register is not stalled; the frame check,
//   header search and realign of the 32-byte frame register are combinational on the input register
// a waiting result stalls the input register: the input stage still takes one more item while it is empty
// reset: fill count cleared, header byte set to 0x42, no item held; frame bytes are not reset
module particle_frame_sync_parser
    import pfsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata,
    pfsp_in_if.sink           rx,
    pfsp_out_if.source        res
);

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic [BYTE_W-1:0] header_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    frame_t            store_reg;
    frame_t            store_next;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           result_next;
    logic              advance;

    // item moves on when the result register is free or being emptied
    assign advance  = s1_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !s1_valid_reg || advance;

    // header register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= HEADER_RESET;
        else if (cfg_we)
            header_reg <= cfg_wdata;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx.ready)
            s1_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            s1_byte_reg <= rx.rx_byte;
    end

    pfsp_frame_eval u_eval (
        .store       (store_reg),
        .fill        (fill_reg),
        .rx_byte     (s1_byte_reg),
        .header_byte (header_reg),
        .store_next  (store_next),
        .fill_next   (fill_next),
        .result      (result_next)
    );

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (advance)
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            store_reg <= store_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result_next;
    end

    // result item fields
    assign res.valid           = out_valid_reg;
    assign res.status          = out_reg.status;
    assign res.resync_skip     = out_reg.resync_skip;
    assign res.frame_length    = out_reg.words[0];
    assign res.pm1_standard    = out_reg.words[1];
    assign res.pm2p5_standard  = out_reg.words[2];
    assign res.pm10p0_standard = out_reg.words[3];
    assign res.pm1_env         = out_reg.words[4];
    assign res.pm2p5_env       = out_reg.words[5];
    assign res.pm10p0_env      = out_reg.words[6];

endmodule

/* verif/tb_particle_frame_sync_parser.sv */
`timescale 1ns / 1ps

import pfsp_pkg::*;

// tracks the frame parser state and holds the result item each accepted byte should give
class frame_sync_scoreboard;
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] store [FRAME_BYTES];
    int unsigned       fill;
    result_t           expected_q [$];
    int unsigned       bytes_in;
    int unsigned       results_seen;
    int unsigned       good_frames;
    int unsigned       resyncs;
    int unsigned       dropped;
    int unsigned       mismatches;
    string             word_names [NUM_WORDS] = '{"frame_length", "pm1_standard",
        "pm2p5_standard", "pm10p0_standard", "pm1_env", "pm2p5_env", "pm10p0_env"};

    function new();
        header = HEADER_RESET;
        fill   = 0;
    endfunction

    function void set_header(input logic [BYTE_W-1:0] value);
        header = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // work out the result item for one accepted byte
    function void note_input(input logic [BYTE_W-1:0] b);
        result_t           r;
        logic [WORD_W-1:0] chk;
        int                i;
        int                w;
        int                skip;

        r = '0;
        r.status = ST_COLLECT;
        bytes_in++;
        // slot 0 only takes the header byte
        if (fill == 0 && b != header) begin
            dropped++;
            expected_q.push_back(r);
            return;
        end
        store[fill] = b;
        fill++;
        if (fill == FRAME_BYTES) begin
            chk = '0;
            for (i = 0; i < SUM_BYTES; i++)
                chk += store[i];
            if (chk == {store[FRAME_BYTES-2], store[FRAME_BYTES-1]}) begin
                r.status = ST_GOOD;
                for (w = 0; w < NUM_WORDS; w++)
                    r.words[w] = {store[2+2*w], store[3+2*w]};
                fill = 0;
                good_frames++;
            end
            else begin
                // realign on the next header byte, or drop everything
                skip = FRAME_BYTES;
                for (i = FRAME_BYTES - 1; i >= 1; i--)
                    if (store[i] == header)
                        skip = i;
                for (i = 0; i + skip < FRAME_BYTES; i++)
                    store[i] = store[skip+i];
                fill = FRAME_BYTES - skip;
                r.status = ST_RESYNC;
                r.resync_skip = skip[SKIP_W-1:0];
                resyncs++;
            end
        end
        expected_q.push_back(r);
    endfunction

    function void report(input string field, input logic [WORD_W-1:0] want_v,
                         input logic [WORD_W-1:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at result %0d, %s: expected %h, got %h",
                     results_seen, field, want_v, got_v);
    endfunction

    // compare one result item with the oldest expectation
    function void check_result(input logic [STATUS_W-1:0] got_status,
                               input logic [SKIP_W-1:0] got_skip,
                               input logic [NUM_WORDS-1:0][WORD_W-1:0] got_words);
        result_t want;
        int      w;

        results_seen++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d arrived with nothing expected", results_seen);
            return;
        end
        want = expected_q.pop_front();
        if (got_status !== want.status)
            report("status", want.status, got_status);
        if (got_skip !== want.resync_skip)
            report("resync_skip", want.resync_skip, got_skip);
        for (w = 0; w < NUM_WORDS; w++)
            if (got_words[w] !== want.words[w])
                report(word_names[w], want.words[w], got_words[w]);
    endfunction
endclass

module tb_particle_frame_sync_parser;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_mode_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [BYTE_W-1:0] cfg_wdata;

    pfsp_in_if  rx_if ();
    pfsp_out_if res_if ();

    frame_sync_scoreboard sb = new();

    logic [31:0] sink_mask = '1;
    logic [4:0]  sink_pos = '0;
    bit          src_idle;
    int          burst_left;
    int          header_writes;

    particle_frame_sync_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_if),
        .res       (res_if)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #5ms;
        $display("timeout waiting for result items");
        $display("status: fail");
        $finish;
    end

    // receiver stalls follow a rotating mask
    always @(posedge clk)
    begin
        res_if.ready <= sink_mask[sink_pos];
        sink_pos <= sink_pos + 5'd1;
    end

    // note accepted bytes and check accepted results in one place
    always @(posedge clk)
    begin
        logic [NUM_WORDS-1:0][WORD_W-1:0] got_words;
        if (rst_n) begin
            if (rx_if.valid && rx_if.ready)
                sb.note_input(rx_if.rx_byte);
            if (res_if.valid && res_if.ready) begin
                got_words[0] = res_if.frame_length;
                got_words[1] = res_if.pm1_standard;
                got_words[2] = res_if.pm2p5_standard;
                got_words[3] = res_if.pm10p0_standard;
                got_words[4] = res_if.pm1_env;
                got_words[5] = res_if.pm2p5_env;
                got_words[6] = res_if.pm10p0_env;
                sb.check_result(res_if.status, res_if.resync_skip, got_words);
            end
        end
    end

    // random byte, leaning toward the extremes
    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // send one byte, in bursts with random gaps between them when the source idles
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = src_idle ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
    endtask

    // build a frame with a valid sum, optionally break it, send the first count bytes
    task automatic send_frame(input fill_mode_t mode, input int hdr_at, input bit corrupt,
                              input int count);
        logic [BYTE_W-1:0] fb [FRAME_BYTES];
        logic [WORD_W-1:0] chk;
        int                i;

        chk = '0;
        for (i = 0; i < SUM_BYTES; i++) begin
            case (mode)
                FILL_ONES:  fb[i] = 8'hFF;
                FILL_ZEROS: fb[i] = 8'h00;
                default:    fb[i] = pick_byte();
            endcase
        end
        fb[0] = sb.header;
        if (hdr_at > 0)
            fb[hdr_at] = sb.header;
        for (i = 0; i < SUM_BYTES; i++)
            chk += fb[i];
        fb[FRAME_BYTES-2] = chk[15:8];
        fb[FRAME_BYTES-1] = chk[7:0];
        if (corrupt)
            fb[FRAME_BYTES-1] ^= 8'h01;
        for (i = 0; i < count; i++)
            push_byte(fb[i]);
    endtask

    // wait until every result item is back and the pipeline is quiet
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_header(input logic [BYTE_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_header(value);
        header_writes++;
    endtask

    // mostly well-formed frames, with broken frames, noise and cut-off frames mixed in
    task automatic run_phase(input int budget);
        int first;
        int kind;
        int n;
        first = sb.bytes_in;
        while (sb.bytes_in - first < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
                send_frame(FILL_RANDOM, 0, 1'b0, FRAME_BYTES);
            else if (kind < 75)
                send_frame(FILL_RANDOM, $urandom_range(1, SUM_BYTES - 1), 1'b1, FRAME_BYTES);
            else if (kind < 82)
                send_frame(FILL_RANDOM, 0, 1'b1, FRAME_BYTES);
            else if (kind < 92) begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(pick_byte());
            end
            else
                send_frame(FILL_RANDOM, 0, 1'b0, $urandom_range(1, FRAME_BYTES - 1));
        end
        // leave a partial frame held across the next header change
        send_frame(FILL_RANDOM, 0, 1'b0, $urandom_range(1, 20));
    endtask

    // main sequence
    initial
    begin
        logic [BYTE_W-1:0] headers [5];
        int                p;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        rx_if.valid <= 1'b0;
        rx_if.rx_byte <= '0;
        src_idle = 1'b1;
        burst_left = 0;
        header_writes = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: dropped bytes, all-ones good frame, broken all-zeros frame with no second header
        sink_mask <= $urandom | 32'h1;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h41);
        send_frame(FILL_ONES, 0, 1'b0, FRAME_BYTES);
        send_frame(FILL_ZEROS, 0, 1'b1, FRAME_BYTES);
        wait_idle();

        // random phases, each under a set header, source idle pattern and receiver stall mask
        headers[0] = HEADER_RESET;
        headers[1] = 8'hFF;
        headers[2] = 8'h00;
        headers[3] = BYTE_W'($urandom_range(1, 254));
        headers[4] = 8'h42;
        for (p = 0; p < 5; p++) begin
            if (p > 0)
                write_header(headers[p]);
            src_idle = (p == 1 || p == 3 || p == 4);
            if (p == 0 || p == 3)
                sink_mask <= '1;
            else
                sink_mask <= $urandom | 32'h11;
            run_phase(130);
            wait_idle();
        end

        $display("sent %0d bytes under %0d header writes", sb.bytes_in, header_writes);
        $display("saw %0d good frames, %0d resyncs, %0d bytes dropped at slot 0",
                 sb.good_frames, sb.resyncs, sb.dropped);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
